/* hw/rtl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* hw/rtl/lmtsf_pkg.sv */
package lmtsf_pkg;

  localparam int MODULES    = 8;
  localparam int CHAR_SLOTS = 16;

  // module indices above 7 never show
  localparam int IDX_LIMIT = (MODULES < 8) ? MODULES : 8;

  localparam int SLOT_W  = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1;
  localparam int CNT_W   = $clog2(IDX_LIMIT + 1);
  localparam int GLYPH_W = 64;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [1:0] CFG_FIRST_MODULE = 2'd0;
  localparam logic [1:0] CFG_TEXT_MODULES = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_PRIME,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // transposed glyph row: bit b is raw byte 7-b, bit src
  function automatic logic [7:0] glyph_pix(input logic [GLYPH_W-1:0] g,
                                           input logic [2:0] src);
    logic [7:0] p;
    p = '0;
    for (int b = 0; b < 8; b++) begin
      p[b] = g[8 * (7 - b) + int'(src)];
    end
    return p;
  endfunction

  // byte window across two neighboring characters
  function automatic logic [7:0] funnel_byte(input logic [7:0] left,
                                             input logic [7:0] right,
                                             input logic [2:0] sh);
    logic [15:0] w;
    w = {left, right} << sh;
    return w[15:8];
  endfunction

endpackage

/* hw/rtl/lmtsf_ram.sv */
module lmtsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/led_matrix_text_scroll_framer.sv */
// channel  | ports                       | moves
// ---------+-----------------------------+-----------------------------------
// in       | in_tvalid/tready/tdata/tuser| load or render request
// out      | out_tvalid/tready/tdata/tlast| display commands of a render
// cfg      | cfg_valid/ready/index/data  | register write, always ready
//
// a load reads the glyph word, then merges the byte and writes it back
// a render runs row by row: prime, fetch, then n commands, n = commands per row
// (text_modules clipped to the modules that exist, nothing when n is 0); the
// glyph ram read port and the one funnel shifter set the pace, one command per
// cycle within a row while the output does not stall
// output stalls hold the sequencer; the last command may still wait in the
// output register when the next request is taken
// reset sets state, config and per-slot valid bits at once, no clearing pass
module led_matrix_text_scroll_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_slot[3:0], font_row[6:4], font_byte[14:7], pix_shift[17:15],
  // vshift[22:18], zero[23]
  input  logic [23:0] in_tdata,
  // op[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // module_index[2:0], command_word[18:3], zero[23:19]
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import lmtsf_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0] first_module_r;
  logic [3:0] text_modules_r;

  logic [2:0]       row_r, row_nxt;
  logic [CNT_W-1:0] m_r, m_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       frac_r, frac_nxt;
  logic [4:0]       vshift_r, vshift_nxt;
  logic [7:0]       prev_r, prev_nxt;

  logic [SLOT_W-1:0] ld_slot_r, ld_slot_nxt;
  logic [2:0]        ld_row_r, ld_row_nxt;
  logic [7:0]        ld_byte_r, ld_byte_nxt;
  logic              ld_ok_r, ld_ok_nxt;

  logic [CHAR_SLOTS-1:0] valid_r;
  logic                  rd_ok_r, rd_ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [15:0] out_cmd_r, out_cmd_nxt;
  logic        out_last_r, out_last_nxt;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [GLYPH_W-1:0] ram_wdata, ram_rdata;

  // input fields
  logic [3:0] in_slot;
  logic [2:0] in_frow;
  logic [7:0] in_fbyte;
  logic [2:0] in_frac;
  logic [4:0] in_vshift;

  assign in_slot   = in_tdata[3:0];
  assign in_frow   = in_tdata[6:4];
  assign in_fbyte  = in_tdata[14:7];
  assign in_frac   = in_tdata[17:15];
  assign in_vshift = in_tdata[22:18];

  logic [4:0]         avail;
  logic [CNT_W-1:0]   cnt_new;
  logic [CNT_W-1:0]   rd_slot;
  logic signed [5:0]  src;
  logic               src_ok;
  logic [GLYPH_W-1:0] glyph;
  logic [7:0]         cur_pix;
  logic [7:0]         cmd_byte;
  logic               out_free;
  logic [GLYPH_W-1:0] merged;
  logic               in_acc;

  assign in_acc = in_tvalid && in_tready;

  // commands per row, clipped to existing modules
  always_comb begin
    avail = (5'(first_module_r) < 5'(IDX_LIMIT)) ?
            5'(IDX_LIMIT) - 5'(first_module_r) : 5'd0;
    cnt_new = (5'(text_modules_r) < avail) ? CNT_W'(text_modules_r) : CNT_W'(avail);
  end

  assign src    = $signed({3'b000, row_r}) + $signed({vshift_r[4], vshift_r});
  assign src_ok = (src[5:3] == 3'b000);
  assign glyph  = rd_ok_r ? ram_rdata : '0;
  assign cur_pix  = src_ok ? glyph_pix(glyph, src[2:0]) : 8'h00;
  assign cmd_byte = funnel_byte(prev_r, cur_pix, frac_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    merged = glyph;
    merged[8 * int'(ld_row_r) +: 8] = ld_byte_r;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    m_nxt         = m_r;
    cnt_nxt       = cnt_r;
    frac_nxt      = frac_r;
    vshift_nxt    = vshift_r;
    prev_nxt      = prev_r;
    ld_slot_nxt   = ld_slot_r;
    ld_row_nxt    = ld_row_r;
    ld_byte_nxt   = ld_byte_r;
    ld_ok_nxt     = ld_ok_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_cmd_nxt   = out_cmd_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ld_slot_r;
    ram_wdata     = merged;
    ram_re        = 1'b0;
    rd_slot       = m_r;
    ram_raddr     = SLOT_W'(rd_slot);

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (in_tuser[0] == OP_LOAD) begin
            ld_slot_nxt = SLOT_W'(in_slot);
            ld_row_nxt  = in_frow;
            ld_byte_nxt = in_fbyte;
            ld_ok_nxt   = (int'(in_slot) < CHAR_SLOTS);
            ram_re      = 1'b1;
            ram_raddr   = SLOT_W'(in_slot);
            rd_ok_nxt   = valid_r[SLOT_W'(in_slot)];
            state_nxt   = ST_LD_WR;
          end else begin
            frac_nxt   = in_frac;
            vshift_nxt = in_vshift;
            cnt_nxt    = cnt_new;
            row_nxt    = 3'd0;
            m_nxt      = '0;
            if (cnt_new != '0) begin
              state_nxt = ST_PRIME;
            end
          end
        end
      end
      ST_LD_WR: begin
        ram_we    = ld_ok_r;
        state_nxt = ST_IDLE;
      end
      ST_PRIME: begin
        rd_slot   = m_r;
        ram_re    = 1'b1;
        ram_raddr = SLOT_W'(rd_slot);
        rd_ok_nxt = (int'(rd_slot) < CHAR_SLOTS) && valid_r[SLOT_W'(rd_slot)];
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        prev_nxt  = cur_pix;
        rd_slot   = m_r + 1'b1;
        ram_re    = 1'b1;
        ram_raddr = SLOT_W'(rd_slot);
        rd_ok_nxt = (int'(rd_slot) < CHAR_SLOTS) && valid_r[SLOT_W'(rd_slot)];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = first_module_r + 3'(m_r);
          out_cmd_nxt   = {4'h0, 4'({1'b0, row_r} + 4'd1), cmd_byte};
          out_last_nxt  = (row_r == 3'd7) && (m_r == cnt_r - 1'b1);
          prev_nxt      = cur_pix;
          if (m_r == cnt_r - 1'b1) begin
            m_nxt = '0;
            if (row_r == 3'd7) begin
              state_nxt = ST_IDLE;
            end else begin
              row_nxt   = row_r + 3'd1;
              state_nxt = ST_PRIME;
            end
          end else begin
            m_nxt     = m_r + 1'b1;
            rd_slot   = m_r + CNT_W'(2);
            ram_re    = 1'b1;
            ram_raddr = SLOT_W'(rd_slot);
            rd_ok_nxt = (int'(rd_slot) < CHAR_SLOTS) && valid_r[SLOT_W'(rd_slot)];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      valid_r        <= '0;
      first_module_r <= 3'd0;
      text_modules_r <= 4'd8;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[ld_slot_r] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIRST_MODULE: first_module_r <= cfg_data[2:0];
          CFG_TEXT_MODULES: text_modules_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    m_r        <= m_nxt;
    cnt_r      <= cnt_nxt;
    frac_r     <= frac_nxt;
    vshift_r   <= vshift_nxt;
    prev_r     <= prev_nxt;
    ld_slot_r  <= ld_slot_nxt;
    ld_row_r   <= ld_row_nxt;
    ld_byte_r  <= ld_byte_nxt;
    ld_ok_r    <= ld_ok_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_last_r <= out_last_nxt;
  end

  lmtsf_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (CHAR_SLOTS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_cmd_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/lmtsf_checker.sv */
`include "assert_macros.svh"

module lmtsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [3:0]  cfg_data
);
  import lmtsf_pkg::*;

  // nothing offered right after reset
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid)

  // a frame in flight keeps the input closed
  `ASSERT_CLK(a_busy_render, clk, rst_n, (out_tvalid && !out_tlast) |-> !in_tready)

  // a load needs its write-back cycle
  `ASSERT_CLK(a_load_two, clk, rst_n,
    (in_tvalid && in_tready && in_tuser[0] == OP_LOAD) |=> !in_tready)

  // row register in the command is 1..8
  `ASSERT_CLK(a_row_range, clk, rst_n,
    out_tvalid |-> (out_tdata[18:11] >= 8'd1 && out_tdata[18:11] <= 8'd8))

  // stalled command holds
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))

endmodule

bind led_matrix_text_scroll_framer lmtsf_checker u_lmtsf_checker (.*);

/* tb/frame_command_checker.sv */
module frame_command_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import lmtsf_pkg::*;

  typedef struct packed {
    logic [2:0]  module_index;
    logic [15:0] command_word;
    logic        last;
  } command_t;

  logic [7:0] glyph_mem [CHAR_SLOTS][8];
  logic [2:0] first_mod;
  logic [3:0] text_mods;
  command_t   commands_due[$];
  int         errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
  end

  // bit b of a pixel row is raw byte 7-b, bit src
  function automatic logic [7:0] column_pixels(int slot, int src);
    logic [7:0] v;
    for (int b = 0; b < 8; b++) begin
      v[b] = glyph_mem[slot][7 - b][src];
    end
    return v;
  endfunction

  task automatic predict_frame(input logic [2:0] frac, input logic [4:0] vsh);
    command_t     cmd;
    logic [127:0] word;
    int           tm, src, idx, pos, per_row, total, n;
    tm      = int'(text_mods);
    per_row = 0;
    for (int m = 0; m < tm; m++) begin
      if (int'(first_mod) + m < IDX_LIMIT) per_row++;
    end
    total = 8 * per_row;
    n     = 0;
    for (int row = 0; row < 8; row++) begin
      src  = row + int'($signed(vsh));
      word = '0;
      if (src >= 0 && src <= 7) begin
        for (int s = 0; s <= tm && s < CHAR_SLOTS; s++) begin
          word = word | ({120'b0, column_pixels(s, src)} << (8 * (tm - s)));
        end
      end
      for (int m = 0; m < tm; m++) begin
        idx = int'(first_mod) + m;
        if (idx < IDX_LIMIT) begin
          pos = (tm - m) * 8 - int'(frac);
          cmd.module_index = idx[2:0];
          cmd.command_word = {8'(row + 1), (pos >= 128) ? 8'h00 : 8'(word >> pos)};
          cmd.last         = (n == total - 1);
          commands_due.push_back(cmd);
          n++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    command_t want;
    if (!rst_n) begin
      for (int s = 0; s < CHAR_SLOTS; s++) begin
        for (int r = 0; r < 8; r++) glyph_mem[s][r] = 8'h00;
      end
      first_mod = 3'd0;
      text_mods = 4'd8;
      commands_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (commands_due.size() == 0) begin
          $error("command with no expectation: tdata %h last %b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = commands_due.pop_front();
          if (out_tdata[2:0] !== want.module_index) begin
            $error("module_index: expected %0d, actual %0d", want.module_index,
                   out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[18:3] !== want.command_word) begin
            $error("command_word: expected %h, actual %h", want.command_word,
                   out_tdata[18:3]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_tlast);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_MODULE: first_mod = cfg_data[2:0];
          CFG_TEXT_MODULES: text_mods = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_LOAD) begin
          if (int'(in_tdata[3:0]) < CHAR_SLOTS)
            glyph_mem[in_tdata[3:0]][in_tdata[6:4]] = in_tdata[14:7];
        end else begin
          predict_frame(in_tdata[17:15], in_tdata[22:18]);
        end
      end
    end
    pending    <= commands_due.size();
    fail_count <= errors;
  end

endmodule

/* tb/led_matrix_text_scroll_framer_tb.sv */
module led_matrix_text_scroll_framer_tb;
  import lmtsf_pkg::*;

  localparam int         CYCLE_LIMIT = 600000;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // char_slot[3:0], font_row[6:4], font_byte[14:7], pix_shift[17:15],
  // vshift[22:18], zero[23]
  logic [23:0] in_tdata;
  // op[0]
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // module_index[2:0], command_word[18:3], zero[23:19]
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;
  int          fail_count;
  int          pending;
  int          cycles;
  logic        no_idle;
  logic        hold_out;

  led_matrix_text_scroll_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frame_command_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL led_matrix_text_scroll_framer");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [3:0] slot, input logic [2:0] frow,
                           input logic [7:0] fbyte, input logic [2:0] frac,
                           input logic [4:0] vsh);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, vsh, frac, fbyte, frow, slot};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_byte(input logic [3:0] slot, input logic [2:0] frow,
                           input logic [7:0] fbyte);
    send_item(OP_LOAD, slot, frow, fbyte, 3'($urandom), 5'($urandom));
  endtask

  task automatic render_frame(input logic [2:0] frac, input logic [4:0] vsh);
    send_item(OP_RENDER, 4'($urandom), 3'($urandom), 8'($urandom), frac, vsh);
  endtask

  // drain all commands, then give a trailing load time to finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] fm, input logic [3:0] tm);
    settle();
    write_reg(CFG_FIRST_MODULE, {1'($urandom), fm});
    write_reg(CFG_TEXT_MODULES, tm);
  endtask

  // mostly within -8..8, sometimes anywhere in the 5-bit field
  function automatic logic [4:0] pick_vshift();
    if ($urandom_range(0, 3) == 0) return 5'($urandom);
    return 5'($urandom_range(0, 16) - 8);
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_out) begin
        gap      = 300;
        hold_out = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [2:0] fm;
    logic [3:0] tm;
    logic [3:0] slot;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_out  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings first
    load_byte(4'd0, 3'd0, 8'hFF);
    load_byte(4'd0, 3'd7, 8'h81);
    load_byte(4'd15, 3'd7, 8'h80);
    load_byte(4'd8, 3'd3, 8'h01);
    load_byte(4'd1, 3'd5, 8'hA5);
    load_byte(4'd2, 3'd2, 8'h5A);
    load_byte(4'd8, 3'd0, 8'h00);
    render_frame(3'd0, 5'd0);
    render_frame(3'd7, 5'd0);
    render_frame(3'd3, 5'b11000);
    render_frame(3'd0, 5'd8);
    render_frame(3'd5, 5'b10000);
    render_frame(3'd1, 5'd15);
    // modules run past the last one
    set_config(3'd5, 4'd5);
    render_frame(3'd4, 5'd2);
    set_config(3'd7, 4'd1);
    render_frame(3'd7, 5'b11111);
    // no text modules: no commands at all
    set_config(3'd0, 4'd0);
    render_frame(3'd2, 5'd0);
    load_byte(4'd3, 3'd4, 8'hC3);
    // more text modules than display modules
    set_config(3'd2, 4'd15);
    render_frame(3'd6, 5'b11101);
    settle();
    write_reg(CFG_SPARE_A, 4'hF);
    write_reg(CFG_SPARE_B, 4'hA);
    render_frame(3'd0, 5'd0);

    for (int ph = 0; ph < 6; ph++) begin
      fm = 3'($urandom);
      case ($urandom_range(0, 9))
        0:       tm = 4'd0;
        1:       tm = 4'($urandom_range(9, 15));
        default: tm = 4'($urandom_range(1, 8));
      endcase
      // the long hold-off needs commands to back up against
      if (ph == 4 && tm == 4'd0) tm = 4'd8;
      set_config(fm, tm);
      no_idle = (ph == 2);
      if (ph == 4) hold_out = 1'b1;
      for (int i = 0; i < 19; i++) begin
        if ((ph == 4 && i < 3) || $urandom_range(0, 9) < 3) begin
          render_frame(3'($urandom), pick_vshift());
        end else begin
          slot = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, int'(tm))) : 4'($urandom);
          load_byte(slot, 3'($urandom), 8'($urandom));
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS led_matrix_text_scroll_framer");
    end else begin
      $display("FAIL led_matrix_text_scroll_framer");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/lmtsf_pkg.sv
hw/rtl/lmtsf_ram.sv
hw/rtl/led_matrix_text_scroll_framer.sv
hw/rtl/lmtsf_checker.sv
tb/frame_command_checker.sv
tb/led_matrix_text_scroll_framer_tb.sv
